/* design/pstt_pkg.sv */
// Shared types and constants of the periodic software timer table.
package pstt_pkg;

  localparam int NUM_SLOTS_DEF = 32;

  localparam int TYPE_W   = 2;
  localparam int PERIOD_W = 32;
  localparam int SLOT_W   = 5;
  localparam int RATE_W   = 20;
  localparam int ACC_W    = 21;
  localparam int MS_W     = 10;
  localparam int CNT_W    = 32;
  localparam int MASK_W   = 32;
  localparam int QCNT_W   = 4;

  localparam logic [ACC_W-1:0]  MS_PER_SECOND = ACC_W'(1000);
  localparam logic [RATE_W-1:0] DEFAULT_RATE  = RATE_W'(1000);

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [TYPE_W-1:0]   req_type;
    logic [PERIOD_W-1:0] period_ms;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [SLOT_W-1:0]   slot_given;
    logic [MASK_W-1:0]   fired_mask;
    logic [MS_W-1:0]     ms_elapsed;
    logic [CNT_W-1:0]    ms_count;
  } rsp_t;

endpackage

/* design/periodic_soft_timer_table_unit.sv */
// Top level of the periodic software timer table: slot memories, divider and slot walk.
//
// A word is accepted on a rising edge with start high and busy low; exactly one
// result word follows, shown on rsp for one cycle with done high. The receiver
// cannot stall, so rsp is valid only in that cycle and must be captured then.
// Add, remove, unused codes and ticks that pass no millisecond answer with
// done on the cycle after acceptance and keep busy low. A tick that passes
// milliseconds runs a restoring divider (one quotient bit at a time, most
// significant first; the quotient never exceeds 1000), then walks the slot
// memories once, one entry per cycle through the synchronous read port, and
// then drains the last read-modify-write before done. The free-slot search
// for an add reads the in-use flags only. cfg_we writes tick_rate_hz and
// clears the rate accumulator; a rate of zero is used as 1000. Write the rate
// only while busy is low.
module periodic_soft_timer_table_unit #(
  parameter int NUM_SLOTS = pstt_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  pstt_pkg::req_t               req,
  input  logic                         cfg_we,
  input  logic [pstt_pkg::RATE_W-1:0]  cfg_wdata,
  output logic                         done,
  output pstt_pkg::rsp_t               rsp
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam int SHIFT_W = pstt_pkg::RATE_W + pstt_pkg::MS_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state;

  // Control and architectural registers
  logic [pstt_pkg::RATE_W-1:0]  tick_rate_hz;
  logic [pstt_pkg::ACC_W-1:0]   rate_acc;
  logic [pstt_pkg::CNT_W-1:0]   ms_total;
  logic [NUM_SLOTS-1:0]         in_use;
  logic [pstt_pkg::QCNT_W-1:0]  div_cnt;
  logic [IDX_W-1:0]             walk_idx;
  logic                         chk_valid;
  logic [IDX_W-1:0]             chk_idx;

  // Working registers of one tick
  logic [pstt_pkg::ACC_W-1:0]   rem;
  logic [pstt_pkg::MS_W-1:0]    quot;
  logic [pstt_pkg::MS_W-1:0]    ms;
  logic [NUM_SLOTS-1:0]         fired;

  // Slot memories
  logic [pstt_pkg::PERIOD_W-1:0] time_left_mem [NUM_SLOTS];
  logic [pstt_pkg::PERIOD_W-1:0] reload_mem    [NUM_SLOTS];
  logic [pstt_pkg::PERIOD_W-1:0] tl_rdata;
  logic [pstt_pkg::PERIOD_W-1:0] rl_rdata;
  logic                          tl_we;
  logic [IDX_W-1:0]              tl_waddr;
  logic [pstt_pkg::PERIOD_W-1:0] tl_wdata;

  // Combinational helpers
  logic [pstt_pkg::RATE_W-1:0]  eff_rate;
  logic [pstt_pkg::ACC_W-1:0]   acc_sum;
  logic [SHIFT_W-1:0]           div_shift;
  logic [pstt_pkg::ACC_W-1:0]   rem_next;
  logic [pstt_pkg::MS_W-1:0]    quot_next;
  logic                         full;
  logic [IDX_W-1:0]             free_idx;
  logic                         accept;
  logic                         add_take;
  logic                         rm_hit;
  logic                         chk_hit;
  logic                         chk_fire;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  assign eff_rate = (tick_rate_hz == '0) ? pstt_pkg::DEFAULT_RATE : tick_rate_hz;
  assign acc_sum  = rate_acc + pstt_pkg::MS_PER_SECOND;

  // One quotient bit per cycle, most significant first
  always_comb begin
    div_shift = SHIFT_W'(eff_rate) << div_cnt;
    rem_next  = rem;
    quot_next = quot;
    if (SHIFT_W'(rem) >= div_shift) begin
      rem_next           = rem - div_shift[pstt_pkg::ACC_W-1:0];
      quot_next[div_cnt] = 1'b1;
    end
  end

  // Lowest free slot
  always_comb begin
    full     = &in_use;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) free_idx = IDX_W'(i);
    end
  end

  assign add_take = accept && (req.req_type == pstt_pkg::REQ_ADD) && !full;
  assign rm_hit   = ({1'b0, req.slot} < (pstt_pkg::SLOT_W + 1)'(NUM_SLOTS))
                    && in_use[req.slot[IDX_W-1:0]];

  // Slot check on the data read in the previous cycle
  assign chk_hit  = chk_valid && in_use[chk_idx];
  assign chk_fire = !(tl_rdata > pstt_pkg::PERIOD_W'(ms));

  always_comb begin
    tl_we    = add_take || chk_hit;
    tl_waddr = add_take ? free_idx : chk_idx;
    if (add_take) begin
      tl_wdata = req.period_ms;
    end else if (chk_fire) begin
      tl_wdata = rl_rdata;
    end else begin
      tl_wdata = tl_rdata - pstt_pkg::PERIOD_W'(ms);
    end
  end

  always_ff @(posedge clk) begin
    if (tl_we) time_left_mem[tl_waddr] <= tl_wdata;
    tl_rdata <= time_left_mem[walk_idx];
  end

  always_ff @(posedge clk) begin
    if (add_take) reload_mem[free_idx] <= req.period_ms;
    rl_rdata <= reload_mem[walk_idx];
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_rate_hz <= pstt_pkg::DEFAULT_RATE;
      rate_acc     <= '0;
      ms_total     <= '0;
      in_use       <= '0;
      div_cnt      <= '0;
      walk_idx     <= '0;
      chk_valid    <= 1'b0;
      chk_idx      <= '0;
      done         <= 1'b0;
    end else begin
      done      <= 1'b0;
      chk_valid <= 1'b0;
      if (cfg_we) begin
        tick_rate_hz <= cfg_wdata;
        rate_acc     <= '0;
      end
      case (state)
        ST_IDLE: begin
          walk_idx <= '0;
          if (accept) begin
            case (req.req_type)
              pstt_pkg::REQ_TICK: begin
                if (acc_sum < pstt_pkg::ACC_W'(eff_rate)) begin
                  rate_acc <= acc_sum;
                  done     <= 1'b1;
                end else begin
                  div_cnt <= pstt_pkg::QCNT_W'(pstt_pkg::MS_W - 1);
                  state   <= ST_DIV;
                end
              end
              pstt_pkg::REQ_ADD: begin
                if (!full) in_use[free_idx] <= 1'b1;
                done <= 1'b1;
              end
              pstt_pkg::REQ_REMOVE: begin
                if (rm_hit) in_use[req.slot[IDX_W-1:0]] <= 1'b0;
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            rate_acc <= rem_next;
            ms_total <= ms_total + pstt_pkg::CNT_W'(quot_next);
            state    <= ST_WALK;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_WALK: begin
          // Issue read of walk_idx; its check runs next cycle
          chk_valid <= 1'b1;
          chk_idx   <= walk_idx;
          if (walk_idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            walk_idx <= walk_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider and walk payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rem   <= acc_sum;
      quot  <= '0;
      fired <= '0;
    end else if (state == ST_DIV) begin
      rem  <= rem_next;
      quot <= quot_next;
      if (div_cnt == '0) ms <= quot_next;
    end
    if (chk_hit && chk_fire) fired[chk_idx] <= 1'b1;
  end

  // Result word
  always_ff @(posedge clk) begin
    rsp.status     <= pstt_pkg::STATUS_OK;
    rsp.slot_given <= '0;
    rsp.fired_mask <= '0;
    rsp.ms_elapsed <= '0;
    rsp.ms_count   <= ms_total;
    if (accept && (req.req_type == pstt_pkg::REQ_ADD)) begin
      if (full) begin
        rsp.status <= pstt_pkg::STATUS_FULL;
      end else begin
        rsp.slot_given <= pstt_pkg::SLOT_W'(free_idx);
      end
    end
    if (state == ST_DRAIN) begin
      // Fold in the last slot's check, which lands at this same edge
      rsp.fired_mask <= pstt_pkg::MASK_W'(fired)
                        | (pstt_pkg::MASK_W'(chk_hit && chk_fire) << chk_idx);
      rsp.ms_elapsed <= ms;
    end
  end

endmodule

/* verif/pstt_checker.sv */
// Checker for the periodic software timer table: predicts each result word and compares it.
module pstt_checker #(
  parameter int NUM_SLOTS = pstt_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  pstt_pkg::req_t              req,
  input  logic                        cfg_we,
  input  logic [pstt_pkg::RATE_W-1:0] cfg_wdata,
  input  logic                        done,
  input  pstt_pkg::rsp_t              rsp,
  output int                          n_failed,
  output int                          n_waiting
);
  import pstt_pkg::*;

  logic [NUM_SLOTS-1:0] armed;
  logic [PERIOD_W-1:0]  remaining [NUM_SLOTS];
  logic [PERIOD_W-1:0]  reload [NUM_SLOTS];
  logic [ACC_W-1:0]     accum;
  logic [CNT_W-1:0]     ms_total;
  logic [RATE_W-1:0]    rate_hz;
  int unsigned          used_slots;
  rsp_t                 expected_rsps[$];
  int                   fail_cnt = 0;
  int                   word_cnt = 0;

  // Apply one request word to the shadow table and return the result it should produce.
  function automatic rsp_t timer_step(req_t w);
    rsp_t        r;
    int unsigned eff;
    int unsigned sum;
    int unsigned whole;
    int          i;
    r = '0;
    r.status = STATUS_OK;
    case (w.req_type)
      REQ_TICK: begin
        eff = (rate_hz == '0) ? int'(DEFAULT_RATE) : int'(rate_hz);
        sum = (int'(accum) + int'(MS_PER_SECOND)) % (1 << ACC_W);
        if (sum >= eff) begin
          whole = sum / eff;
          sum = sum - whole * eff;
          ms_total = ms_total + CNT_W'(whole);
          r.ms_elapsed = MS_W'(whole);
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (armed[i]) begin
              if (remaining[i] > PERIOD_W'(whole)) begin
                remaining[i] = remaining[i] - PERIOD_W'(whole);
              end else begin
                r.fired_mask[i] = 1'b1;
                remaining[i] = reload[i];
              end
            end
          end
        end
        accum = ACC_W'(sum);
      end
      REQ_ADD: begin
        r.status = STATUS_FULL;
        if (used_slots < NUM_SLOTS) begin
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (!armed[i] && r.status == STATUS_FULL) begin
              armed[i] = 1'b1;
              remaining[i] = w.period_ms;
              reload[i] = w.period_ms;
              used_slots++;
              r.status = STATUS_OK;
              r.slot_given = SLOT_W'(i);
            end
          end
        end
      end
      REQ_REMOVE: begin
        // A slot that is already free stays as it is.
        if (int'(w.slot) < NUM_SLOTS && armed[w.slot]) begin
          armed[w.slot] = 1'b0;
          remaining[w.slot] = '0;
          reload[w.slot] = '0;
          used_slots--;
        end
      end
      default: begin
      end
    endcase
    r.ms_count = ms_total;
    return r;
  endfunction

  always @(posedge clk) begin : watch_words
    rsp_t want;
    int   i;
    if (rst) begin
      armed = '0;
      for (i = 0; i < NUM_SLOTS; i++) begin
        remaining[i] = '0;
        reload[i] = '0;
      end
      accum = '0;
      ms_total = '0;
      rate_hz = DEFAULT_RATE;
      used_slots = 0;
      expected_rsps.delete();
    end else begin
      if (done) begin
        word_cnt++;
        if (expected_rsps.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d arrived with nothing expected: count %0d", word_cnt,
                     rsp.ms_count);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status || rsp.slot_given !== want.slot_given ||
              rsp.fired_mask !== want.fired_mask || rsp.ms_elapsed !== want.ms_elapsed ||
              rsp.ms_count !== want.ms_count) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("result %0d mismatch (exp/act): status %0d/%0d slot %0d/%0d %s",
                       word_cnt, want.status, rsp.status, want.slot_given, rsp.slot_given,
                       $sformatf("fired %h/%h ms %0d/%0d count %0d/%0d",
                                 want.fired_mask, rsp.fired_mask, want.ms_elapsed,
                                 rsp.ms_elapsed, want.ms_count, rsp.ms_count));
          end
        end
      end
      if (cfg_we) begin
        rate_hz = cfg_wdata;
        accum = '0;
      end
      if (start && !busy)
        expected_rsps.push_back(timer_step(req));
    end
    n_failed <= fail_cnt;
    n_waiting <= expected_rsps.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the periodic software timer table: stimulus, watchdog and verdict.
module tb_top;
  import pstt_pkg::*;

  // Spare request code; the block must leave its state alone on it.
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  // A tick that passes milliseconds keeps the block busy longest; allow a wide margin.
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 60;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 115;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  req_t              req       = '0;
  logic              cfg_we    = 1'b0;
  logic [RATE_W-1:0] cfg_wdata = '0;
  logic              busy;
  logic              done;
  rsp_t              rsp;
  int                n_failed;
  int                n_waiting;
  int                idle_pct     = 0;
  int                quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  periodic_soft_timer_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .rsp       (rsp)
  );

  pstt_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .rsp       (rsp),
    .n_failed  (n_failed),
    .n_waiting (n_waiting)
  );

  function automatic req_t timer_word(logic [TYPE_W-1:0] kind, logic [PERIOD_W-1:0] period,
                                      logic [SLOT_W-1:0] idx);
    req_t w;
    w.req_type = kind;
    w.period_ms = period;
    w.slot = idx;
    return w;
  endfunction

  // Offer one word and hold it until the block takes it. Start stays high on
  // return so words can go back to back; drop it only for a gap.
  task automatic send_word(input req_t w);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Pause the sender until every result word is back and the block is idle.
  task automatic drain_words();
    start <= 1'b0;
    do @(posedge clk); while (n_waiting != 0 || busy);
  endtask

  // Write the tick rate; only legal with nothing in flight.
  task automatic set_tick_rate(input logic [RATE_W-1:0] rate);
    drain_words();
    cfg_we <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Abort if nothing moves in either direction for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                p;
    int                n;
    int                add_pct;
    int                rm_pct;
    int unsigned       roll;
    logic [RATE_W-1:0] rate;
    req_t              w;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset rate of 1000: one millisecond per tick.
    send_word(timer_word(REQ_TICK, '0, '0));
    send_word(timer_word(REQ_ADD, 32'd0, '0));         // zero period: fires every tick
    send_word(timer_word(REQ_ADD, 32'd1, '0));
    send_word(timer_word(REQ_ADD, '1, 5'd31));         // longest period
    send_word(timer_word(REQ_ADD, 32'd2, '0));
    send_word(timer_word(REQ_TICK, '1, 5'd31));
    send_word(timer_word(REQ_TICK, '0, '0));
    send_word(timer_word(REQ_REMOVE, '0, 5'd1));
    send_word(timer_word(REQ_REMOVE, '1, 5'd1));       // already free: no change
    send_word(timer_word(REQ_REMOVE, '0, 5'd31));      // never used
    send_word(timer_word(REQ_UNUSED, '1, 5'd31));
    send_word(timer_word(REQ_ADD, 32'd5, '0));         // reuses the lowest free slot
    send_word(timer_word(REQ_TICK, '0, '0));
    send_word(timer_word(REQ_REMOVE, '0, 5'd0));
    send_word(timer_word(REQ_REMOVE, '0, 5'd2));
    send_word(timer_word(REQ_ADD, 32'd0, '0));
    send_word(timer_word(REQ_TICK, '0, '0));
    // Slowest rate, so one tick passes the full 1000 ms.
    set_tick_rate(20'd1);
    send_word(timer_word(REQ_TICK, '0, '0));
    send_word(timer_word(REQ_TICK, '0, '0));
    // Zero rate falls back to 1000.
    set_tick_rate(20'd0);
    send_word(timer_word(REQ_TICK, '0, '0));
    // A very fast rate of 1000000: ticks stay below the rate and pass nothing.
    set_tick_rate(20'd1000000);
    send_word(timer_word(REQ_TICK, '0, '0));
    send_word(timer_word(REQ_TICK, '0, '0));

    // Random part: each phase picks a rate, a request mix and a sender pace.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       rate = 20'd1;
        1:       rate = 20'd0;
        2:       rate = 20'd1000;
        3:       rate = 20'd1000000;
        4:       rate = '1;
        5:       rate = 20'd3;
        6:       rate = 20'd999;
        7:       rate = 20'd1001;
        8:       rate = 20'd2500;
        9:       rate = RATE_W'($urandom_range(1000000, 1));
        10:      rate = RATE_W'($urandom_range(5000, 1));
        default: rate = 20'd1000;
      endcase
      // Add-heavy phases fill the table and hit the full case.
      add_pct = (p % 3 == 0) ? 55 : ((p % 3 == 1) ? 20 : 30);
      rm_pct  = (p % 3 == 0) ? 8 : ((p % 3 == 1) ? 20 : 25);
      // Sender pace: steady, idle half the time, steady, idle 13 in 100.
      case (p % 4)
        1:       idle_pct = 50;
        3:       idle_pct = 13;
        default: idle_pct = 0;
      endcase
      set_tick_rate(rate);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        w.period_ms = $urandom;
        w.slot = SLOT_W'($urandom_range(31));
        roll = $urandom_range(99);
        if (roll < add_pct) begin
          w.req_type = REQ_ADD;
          // Favor short periods so slots fire within the phase.
          roll = $urandom_range(99);
          if (roll < 30)
            w.period_ms = $urandom_range(3);
          else if (roll < 70)
            w.period_ms = $urandom_range(50, 4);
          else if (roll < 85)
            w.period_ms = $urandom_range(3000, 51);
          else if (roll < 92)
            w.period_ms = roll[0] ? '1 : '0;
        end else if (roll < add_pct + rm_pct) begin
          w.req_type = REQ_REMOVE;
        end else if (roll < add_pct + rm_pct + 3) begin
          w.req_type = REQ_UNUSED;
        end else begin
          w.req_type = REQ_TICK;
        end
        send_word(w);
        // Now and then hold off until the block has answered everything.
        if ($urandom_range(99) < 2)
          drain_words();
      end
    end

    drain_words();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_failed == 0 && n_waiting == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
